// ===== rtl/tri_pkg.sv =====
//------------------------------------------------------------------------------
// tri_pkg
// Shared constants of the three-circle trilateration block.
//------------------------------------------------------------------------------
`default_nettype none

package tri_pkg;

	localparam int COORD_WIDTH_DEF = 24;

	// Operand chunk width of the pipelined multipliers.
	localparam int MUL_CHUNK = 24;

	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_A_X = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_A_Y = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_B_X = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_B_Y = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_C_X = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_C_Y = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/tri_mul.sv =====
//------------------------------------------------------------------------------
// tri_mul
// Two-stage signed multiplier built from chunk products, with a side bus.
//------------------------------------------------------------------------------
`default_nettype none

module tri_mul #(
	parameter int AW  = 8,
	parameter int BW  = 8,
	parameter int SDW = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic signed [AW-1:0]  a,
	input  wire logic signed [BW-1:0]  b,
	input  wire logic [SDW-1:0]        side_in,
	output logic signed [AW+BW-1:0]    p,
	output logic [SDW-1:0]             side_out
);

	localparam int CK = tri_pkg::MUL_CHUNK;
	localparam int NA = (AW + CK - 1) / CK;
	localparam int NB = (BW + CK - 1) / CK;
	localparam int PW = AW + BW;

	logic [AW-1:0]      ma;
	logic [BW-1:0]      mb;
	logic [NA*CK-1:0]   pa;
	logic [NB*CK-1:0]   pb;
	logic [2*CK-1:0]    pp_s1 [NA][NB];
	logic               sg_s1;
	logic [SDW-1:0]     side_s1;
	logic [PW-1:0]      acc;

	always_comb begin
		ma = a[AW-1] ? AW'(-a) : AW'(a);
		mb = b[BW-1] ? BW'(-b) : BW'(b);
		pa = (NA*CK)'(ma);
		pb = (NB*CK)'(mb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= pa[i*CK +: CK] * pb[j*CK +: CK];
				end
			end
			sg_s1 <= a[AW-1] ^ b[BW-1];
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PW'(pp_s1[i][j]) << ((i + j) * CK));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sg_s1 ? $signed(-acc) : $signed(acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_out <= '0;
		end else if (en) begin
			side_s1  <= side_in;
			side_out <= side_s1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tri_sqrt.sv =====
//------------------------------------------------------------------------------
// tri_sqrt
// Pipelined integer square root, one result bit per stage, with a side bus.
//------------------------------------------------------------------------------
`default_nettype none

module tri_sqrt #(
	parameter int IW  = 16,
	parameter int SDW = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [IW-1:0]    x,
	input  wire logic [SDW-1:0]   side_in,
	output logic [IW/2-1:0]       s,
	output logic [SDW-1:0]        side_out
);

	localparam int N  = IW / 2;
	localparam int RW = N + 3;

	logic [IW-1:0]  rad_q  [N];
	logic [RW-1:0]  rem_q  [N];
	logic [N-1:0]   root_q [N];
	logic [SDW-1:0] sd_q   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [IW-1:0]  rad_i;
		logic [RW-1:0]  rem_i;
		logic [N-1:0]   root_i;
		logic [SDW-1:0] sd_i;
		logic [RW-1:0]  cand;
		logic [RW-1:0]  trial;

		if (k == 0) begin : g_first
			assign rad_i  = x;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sd_i   = side_in;
		end else begin : g_next
			assign rad_i  = rad_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign sd_i   = sd_q[k-1];
		end

		assign cand  = {rem_i[RW-3:0], rad_i[IW-1 -: 2]};
		assign trial = RW'({root_i, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= rad_i << 2;
				if (cand >= trial) begin
					rem_q[k]  <= cand - trial;
					root_q[k] <= {root_i[N-2:0], 1'b1};
				end else begin
					rem_q[k]  <= cand;
					root_q[k] <= {root_i[N-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_q[k] <= '0;
			end else if (en) begin
				sd_q[k] <= sd_i;
			end
		end
	end

	assign s        = root_q[N-1];
	assign side_out = sd_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/tri_div.sv =====
//------------------------------------------------------------------------------
// tri_div
// Pipelined restoring divider for a quotient of known width, with a side bus.
//------------------------------------------------------------------------------
`default_nettype none

module tri_div #(
	parameter int NW  = 32,
	parameter int DW  = 16,
	parameter int QW  = 16,
	parameter int SDW = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [NW-1:0]    n,
	input  wire logic [DW-1:0]    d,
	input  wire logic [SDW-1:0]   side_in,
	output logic [QW-1:0]         q,
	output logic [SDW-1:0]        side_out
);

	logic [DW-1:0]  rem_q [QW];
	logic [QW-1:0]  lo_q  [QW];
	logic [QW-1:0]  quo_q [QW];
	logic [DW-1:0]  d_q   [QW];
	logic [SDW-1:0] sd_q  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0]  rem_i;
		logic [QW-1:0]  lo_i;
		logic [QW-1:0]  quo_i;
		logic [DW-1:0]  d_i;
		logic [SDW-1:0] sd_i;
		logic [DW:0]    cand;

		if (k == 0) begin : g_first
			assign rem_i = DW'(n >> QW);
			assign lo_i  = n[QW-1:0];
			assign quo_i = '0;
			assign d_i   = d;
			assign sd_i  = side_in;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign lo_i  = lo_q[k-1];
			assign quo_i = quo_q[k-1];
			assign d_i   = d_q[k-1];
			assign sd_i  = sd_q[k-1];
		end

		assign cand = {rem_i, lo_i[QW-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				lo_q[k] <= lo_i << 1;
				d_q[k]  <= d_i;
				if (cand >= {1'b0, d_i}) begin
					rem_q[k] <= DW'(cand - {1'b0, d_i});
					quo_q[k] <= {quo_i[QW-2:0], 1'b1};
				end else begin
					rem_q[k] <= DW'(cand);
					quo_q[k] <= {quo_i[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd_q[k] <= '0;
			end else if (en) begin
				sd_q[k] <= sd_i;
			end
		end
	end

	assign q        = quo_q[QW-1];
	assign side_out = sd_q[QW-1];

endmodule

`default_nettype wire

// ===== rtl/tri_pair.sv =====
//------------------------------------------------------------------------------
// tri_pair
// One lane: intersects two circles and picks the first point inside a third.
//------------------------------------------------------------------------------
`default_nettype none

module tri_pair #(
	parameter int CW = tri_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 v_in,
	input  wire logic signed [CW-1:0] x1,
	input  wire logic signed [CW-1:0] y1,
	input  wire logic signed [CW-1:0] x2,
	input  wire logic signed [CW-1:0] y2,
	input  wire logic signed [CW-1:0] x3,
	input  wire logic signed [CW-1:0] y3,
	input  wire logic [CW-2:0]        r1,
	input  wire logic [CW-2:0]        r2,
	input  wire logic [CW-2:0]        r3,
	output logic                      v_out,
	output logic signed [CW-1:0]      px,
	output logic signed [CW-1:0]      py,
	output logic                      pvalid
);

	localparam int RW   = CW - 1;
	localparam int DW   = CW + 1;
	localparam int LW   = 2 * DW;
	localparam int MW   = LW + 1;
	localparam int EW   = 2 * MW;
	localparam int NPW  = DW + MW + 2;
	localparam int NW1  = NPW + 1;
	localparam int NUMW = NW1 + 1;
	localparam int QW   = CW + 2;
	localparam int XW   = CW + 4;
	localparam int EXW  = XW + 1;
	localparam int SQW  = 2 * EXW;
	localparam int RLW  = 2 * RW + LW + 2;
	localparam int S1W  = 2 + 2 * DW + 2 * RW;
	localparam int S6W  = S1W + LW + MW;

	localparam logic signed [XW-1:0] SAT_HI = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [XW-1:0] SAT_LO = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > SAT_HI) begin
			r = {1'b0, {(CW-1){1'b1}}};
		end else if (v < SAT_LO) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	// Squares and the circle-difference terms.
	logic                   v_s1, v_s2, v_s3;
	logic signed [DW-1:0]   dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic [RW-1:0]          r1_s1, r2_s1, r3_s1;
	logic signed [2*DW-1:0] dxx_s2, dyy_s2;
	logic [2*RW-1:0]        r1q_s2, r2q_s2, r3q_s2, r1q_s3, r3q_s3;
	logic [LW-1:0]          l_s3;
	logic signed [MW-1:0]   m_s3;
	logic                   ok_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
			dy_s1  <= $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});
			r1_s1  <= r1;
			r2_s1  <= r2;
			r3_s1  <= r3;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			r1q_s2 <= r1_s1 * r1_s1;
			r2q_s2 <= r2_s1 * r2_s1;
			r3q_s2 <= r3_s1 * r3_s1;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			l_s3   <= LW'($unsigned(dxx_s2)) + LW'($unsigned(dyy_s2));
			m_s3   <= $signed(MW'(r1q_s2)) - $signed(MW'(r2q_s2))
			        + $signed(MW'($unsigned(dxx_s2))) + $signed(MW'($unsigned(dyy_s2)));
			r1q_s3 <= r1q_s2;
			r3q_s3 <= r3q_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			ok_s3 <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			ok_s3 <= dy_s2 != '0;
		end
	end

	// Discriminant E = 4 r1^2 L - M^2.
	logic signed [RLW-1:0]  rl_s5;
	logic signed [EW-1:0]   mm_s5;
	logic [S1W-1:0]         side1_s5;
	logic [LW+MW-1:0]       side2_s5;
	logic                   v_s5, ok_s5;
	logic signed [DW-1:0]   dx_s5, dy_s5;
	logic [2*RW-1:0]        r3q_s5;
	logic [LW-1:0]          l_s5;
	logic signed [MW-1:0]   m_s5;
	logic signed [EW-1:0]   e_c;

	tri_mul #(.AW(2*RW+1), .BW(LW+1), .SDW(S1W)) u_mul_rl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        ($signed({1'b0, r1q_s3})),
		.b        ($signed({1'b0, l_s3})),
		.side_in  ({v_s3, ok_s3, dx_s3, dy_s3, r3q_s3}),
		.p        (rl_s5),
		.side_out (side1_s5)
	);

	tri_mul #(.AW(MW), .BW(MW), .SDW(LW+MW)) u_mul_mm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        (m_s3),
		.b        (m_s3),
		.side_in  ({l_s3, m_s3}),
		.p        (mm_s5),
		.side_out (side2_s5)
	);

	assign {v_s5, ok_s5, dx_s5, dy_s5, r3q_s5} = side1_s5;
	assign {l_s5, m_s5} = side2_s5;
	assign e_c = (EW'(rl_s5) <<< 2) - mm_s5;

	logic [EW-1:0]  e_s6;
	logic [S6W-1:0] side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s6 <= e_c[EW-1] ? '0 : $unsigned(e_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else if (en) begin
			side_s6 <= {v_s5, ok_s5 & ~e_c[EW-1], dx_s5, dy_s5, r3q_s5, l_s5, m_s5};
		end
	end

	// Square root of the discriminant.
	logic [MW-1:0]          s_s7;
	logic [S6W-1:0]         side_s7;
	logic                   v_s7, ok_s7;
	logic signed [DW-1:0]   dx_s7, dy_s7;
	logic [2*RW-1:0]        r3q_s7;
	logic [LW-1:0]          l_s7;
	logic signed [MW-1:0]   m_s7;
	logic signed [DW:0]     ady_s7;

	tri_sqrt #(.IW(EW), .SDW(S6W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.x        (e_s6),
		.side_in  (side_s6),
		.s        (s_s7),
		.side_out (side_s7)
	);

	assign {v_s7, ok_s7, dx_s7, dy_s7, r3q_s7, l_s7, m_s7} = side_s7;
	assign ady_s7 = dy_s7[DW-1] ? -(DW+1)'(dy_s7) : (DW+1)'(dy_s7);

	// Numerator products.
	logic signed [DW+MW-1:0]   ax_s8, ay_s8;
	logic signed [DW+MW+1:0]   pxp_s8;
	logic signed [DW+MW:0]     pyp_s8;
	logic                      v_s8, ok_s8, dyneg_s8;
	logic [2*RW-1:0]           r3q_s8;
	logic [LW-1:0]             l_s8;

	tri_mul #(.AW(DW), .BW(MW), .SDW(2)) u_mul_ax (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        (dx_s7),
		.b        (m_s7),
		.side_in  ({v_s7, ok_s7}),
		.p        (ax_s8),
		.side_out ({v_s8, ok_s8})
	);

	tri_mul #(.AW(DW), .BW(MW), .SDW(2*RW)) u_mul_ay (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        (dy_s7),
		.b        (m_s7),
		.side_in  (r3q_s7),
		.p        (ay_s8),
		.side_out (r3q_s8)
	);

	tri_mul #(.AW(DW+1), .BW(MW+1), .SDW(LW)) u_mul_px (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        (ady_s7),
		.b        ($signed({1'b0, s_s7})),
		.side_in  (l_s7),
		.p        (pxp_s8),
		.side_out (l_s8)
	);

	tri_mul #(.AW(DW), .BW(MW+1), .SDW(1)) u_mul_py (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        (dx_s7),
		.b        ($signed({1'b0, s_s7})),
		.side_in  (dy_s7[DW-1]),
		.p        (pyp_s8),
		.side_out (dyneg_s8)
	);

	// Numerators: first x, second x, first y, second y.
	logic signed [NW1-1:0] n_s9 [4];
	logic                  v_s9, ok_s9;
	logic [2*RW-1:0]       r3q_s9;
	logic [LW-1:0]         l_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s9[0] <= NW1'(ax_s8) + NW1'(pxp_s8);
			n_s9[1] <= NW1'(ax_s8) - NW1'(pxp_s8);
			n_s9[2] <= dyneg_s8 ? NW1'(ay_s8) + NW1'(pyp_s8) : NW1'(ay_s8) - NW1'(pyp_s8);
			n_s9[3] <= dyneg_s8 ? NW1'(ay_s8) - NW1'(pyp_s8) : NW1'(ay_s8) + NW1'(pyp_s8);
			r3q_s9  <= r3q_s8;
			l_s9    <= l_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			ok_s9 <= 1'b0;
		end else if (en) begin
			v_s9  <= v_s8;
			ok_s9 <= ok_s8;
		end
	end

	// Round to nearest with ties away from zero: (|n| + L) / 2L.
	logic [NUMW-1:0] num_s10 [4];
	logic            sg_s10  [4];
	logic [LW:0]     d2l_s10;
	logic            v_s10, ok_s10;
	logic [2*RW-1:0] r3q_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				num_s10[k] <= (n_s9[k][NW1-1] ? NUMW'($unsigned(-n_s9[k]))
				                              : NUMW'($unsigned(n_s9[k]))) + NUMW'(l_s9);
				sg_s10[k]  <= n_s9[k][NW1-1];
			end
			d2l_s10 <= {l_s9, 1'b0};
			r3q_s10 <= r3q_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10  <= 1'b0;
			ok_s10 <= 1'b0;
		end else if (en) begin
			v_s10  <= v_s9;
			ok_s10 <= ok_s9;
		end
	end

	logic [QW-1:0]   q_s11  [4];
	logic            sg_s11 [4];
	logic            v_s11, ok_s11;
	logic [2*RW-1:0] r3q_s11;

	for (genvar k = 0; k < 4; k++) begin : g_div
		if (k == 0) begin : g_lead
			tri_div #(.NW(NUMW), .DW(LW+1), .QW(QW), .SDW(3+2*RW)) u_div (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.n        (num_s10[k]),
				.d        (d2l_s10),
				.side_in  ({v_s10, ok_s10, r3q_s10, sg_s10[k]}),
				.q        (q_s11[k]),
				.side_out ({v_s11, ok_s11, r3q_s11, sg_s11[k]})
			);
		end else begin : g_rest
			tri_div #(.NW(NUMW), .DW(LW+1), .QW(QW), .SDW(1)) u_div (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.n        (num_s10[k]),
				.d        (d2l_s10),
				.side_in  (sg_s10[k]),
				.q        (q_s11[k]),
				.side_out (sg_s11[k])
			);
		end
	end

	// Candidate points and their distance to the third anchor.
	logic signed [XW-1:0]  pt_s12 [4];
	logic signed [XW-1:0]  pt_s13 [4];
	logic signed [XW-1:0]  pt_s14 [4];
	logic signed [XW-1:0]  pt_s15 [4];
	logic signed [EXW-1:0] e_s13  [4];
	logic signed [SQW-1:0] sq_s14 [4];
	logic [2*RW-1:0]       r3q_s12, r3q_s13, r3q_s14;
	logic                  v_s12, v_s13, v_s14, v_s15;
	logic                  ok_s12, ok_s13, ok_s14, ok_s15;
	logic                  in0_s15, in1_s15;
	logic [SQW:0]          d0_c, d1_c;

	assign d0_c = (SQW+1)'($unsigned(sq_s14[0])) + (SQW+1)'($unsigned(sq_s14[2]));
	assign d1_c = (SQW+1)'($unsigned(sq_s14[1])) + (SQW+1)'($unsigned(sq_s14[3]));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pt_s12[k] <= ((k < 2) ? XW'(x1) : XW'(y1))
				           + (sg_s11[k] ? -$signed(XW'(q_s11[k])) : $signed(XW'(q_s11[k])));
				e_s13[k]  <= ((k < 2) ? EXW'(x3) : EXW'(y3)) - EXW'(pt_s12[k]);
				sq_s14[k] <= e_s13[k] * e_s13[k];
				pt_s13[k] <= pt_s12[k];
				pt_s14[k] <= pt_s13[k];
				pt_s15[k] <= pt_s14[k];
			end
			r3q_s12 <= r3q_s11;
			r3q_s13 <= r3q_s12;
			r3q_s14 <= r3q_s13;
			in0_s15 <= d0_c < (SQW+1)'(r3q_s14);
			in1_s15 <= d1_c < (SQW+1)'(r3q_s14);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12  <= 1'b0;
			v_s13  <= 1'b0;
			v_s14  <= 1'b0;
			v_s15  <= 1'b0;
			ok_s12 <= 1'b0;
			ok_s13 <= 1'b0;
			ok_s14 <= 1'b0;
			ok_s15 <= 1'b0;
			v_out  <= 1'b0;
		end else if (en) begin
			v_s12  <= v_s11;
			v_s13  <= v_s12;
			v_s14  <= v_s13;
			v_s15  <= v_s14;
			ok_s12 <= ok_s11;
			ok_s13 <= ok_s12;
			ok_s14 <= ok_s13;
			ok_s15 <= ok_s14;
			v_out  <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ok_s15 && in0_s15) begin
				px     <= sat(pt_s15[0]);
				py     <= sat(pt_s15[2]);
				pvalid <= 1'b1;
			end else if (ok_s15 && in1_s15) begin
				px     <= sat(pt_s15[1]);
				py     <= sat(pt_s15[3]);
				pvalid <= 1'b1;
			end else begin
				px     <= '0;
				py     <= '0;
				pvalid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/three_circle_trilateration.sv =====
//------------------------------------------------------------------------------
// three_circle_trilateration
// Intersects three range circles pairwise and reports one point per pair.
//------------------------------------------------------------------------------
// The user must write the anchor positions over the cfg channel before use,
// while no item is in flight; the block does not enforce this. Each input
// item carries the three measured ranges; each output item carries, for the
// pairs A-B, A-C and B-C, the first intersection point that lies strictly
// inside the remaining circle and a valid flag. Three identical lanes, one
// per pair, run side by side and their results are merged into one output
// register. The pipeline depth comes mostly from the square-root pipeline of
// the discriminant, one result bit per stage, and from the dividers, one
// quotient bit per stage.
// Throughput is one item per cycle while the output is not stalled.
// Reset clears the anchor registers to zero and empties the pipeline.
// When the receiver holds m_axis_tready low with an item waiting, the whole
// pipeline holds and s_axis_tready drops until that item is taken.
//------------------------------------------------------------------------------
`default_nettype none

module three_circle_trilateration #(
	parameter int COORD_WIDTH = tri_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       cfg_valid,
	output logic                                            cfg_ready,
	input  wire logic [tri_pkg::CFG_ADDR_W-1:0]             cfg_addr,
	input  wire logic [COORD_WIDTH-1:0]                     cfg_data,
	input  wire logic                                       s_axis_tvalid,
	output logic                                            s_axis_tready,
	// range_a, range_b, range_c
	input  wire logic [((3*(COORD_WIDTH-1)+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                            m_axis_tvalid,
	input  wire logic                                       m_axis_tready,
	// ab_x, ab_y, ab_valid, ac_x, ac_y, ac_valid, bc_x, bc_y, bc_valid
	output logic [((3*(2*COORD_WIDTH+1)+7)/8)*8-1:0]        m_axis_tdata
);

	localparam int CW  = COORD_WIDTH;
	localparam int RW  = CW - 1;
	localparam int TOW = ((3 * (2 * CW + 1) + 7) / 8) * 8;

	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [RW-1:0]        ra, rb, rc;
	logic                 en;
	logic                 v_in;
	logic                 v_ab, v_ac, v_bc;
	logic signed [CW-1:0] ab_x, ab_y, ac_x, ac_y, bc_x, bc_y;
	logic                 ab_valid, ac_valid, bc_valid;
	logic                 m_tvalid_q;
	logic [TOW-1:0]       m_tdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				tri_pkg::REG_ANCHOR_A_X: ax_q <= cfg_data;
				tri_pkg::REG_ANCHOR_A_Y: ay_q <= cfg_data;
				tri_pkg::REG_ANCHOR_B_X: bx_q <= cfg_data;
				tri_pkg::REG_ANCHOR_B_Y: by_q <= cfg_data;
				tri_pkg::REG_ANCHOR_C_X: cx_q <= cfg_data;
				tri_pkg::REG_ANCHOR_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en            = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign v_in          = s_axis_tvalid && en;
	assign ra            = s_axis_tdata[0 +: RW];
	assign rb            = s_axis_tdata[RW +: RW];
	assign rc            = s_axis_tdata[2*RW +: RW];

	tri_pair #(.CW(CW)) u_lane_ab (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_in),
		.x1     (ax_q),
		.y1     (ay_q),
		.x2     (bx_q),
		.y2     (by_q),
		.x3     (cx_q),
		.y3     (cy_q),
		.r1     (ra),
		.r2     (rb),
		.r3     (rc),
		.v_out  (v_ab),
		.px     (ab_x),
		.py     (ab_y),
		.pvalid (ab_valid)
	);

	tri_pair #(.CW(CW)) u_lane_ac (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_in),
		.x1     (ax_q),
		.y1     (ay_q),
		.x2     (cx_q),
		.y2     (cy_q),
		.x3     (bx_q),
		.y3     (by_q),
		.r1     (ra),
		.r2     (rc),
		.r3     (rb),
		.v_out  (v_ac),
		.px     (ac_x),
		.py     (ac_y),
		.pvalid (ac_valid)
	);

	tri_pair #(.CW(CW)) u_lane_bc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_in),
		.x1     (bx_q),
		.y1     (by_q),
		.x2     (cx_q),
		.y2     (cy_q),
		.x3     (ax_q),
		.y3     (ay_q),
		.r1     (rb),
		.r2     (rc),
		.r3     (ra),
		.v_out  (v_bc),
		.px     (bc_x),
		.py     (bc_y),
		.pvalid (bc_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= v_ab & v_ac & v_bc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= TOW'({bc_valid, bc_y, bc_x, ac_valid, ac_y, ac_x,
			                   ab_valid, ab_y, ab_x});
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire
